@@ rtl/std_pkg.sv @@
package std_pkg;

   localparam int ShortLen    = 8;
   localparam int LongLen     = 64;
   localparam int SlotsPerDay = 8;
   localparam int ShortK      = $clog2(ShortLen);
   localparam int LongK       = $clog2(LongLen);
   localparam int SlotW       = $clog2(SlotsPerDay);
   localparam int CntW        = $clog2(SlotsPerDay + 1);
   localparam int NumDays     = 7;
   localparam int SlotAddrW   = $clog2(NumDays * SlotsPerDay);

   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_OFFSET    = 2'd1;
   localparam logic [1:0] CSR_DEFAULT   = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic               read_ok;
      logic signed [11:0] temperature;
      logic [9:0]         humidity;
      logic [2:0]         weekday;
      logic [10:0]        minute_of_day;
      logic [2:0]         slot_index;
      logic signed [11:0] slot_setpoint;
      logic [10:0]        slot_start;
      logic [10:0]        slot_end;
   } req_type;

   typedef struct packed {
      logic signed [11:0] corrected_temp;
      logic signed [11:0] avg_temp_short;
      logic signed [11:0] avg_temp_long;
      logic [9:0]         avg_humid_short;
      logic signed [11:0] active_setpoint;
      logic               need_heating;
      logic               need_cooling;
      logic signed [3:0]  program_day;
      logic signed [3:0]  program_slot;
      logic               report_changed;
   } rsp_type;

   typedef struct packed {
      logic signed [11:0] sp;
      logic [10:0]        start;
      logic [10:0]        stop;
   } slot_type;

   // weekday 0 (and 7) is sunday, mapped to day 6
   function automatic logic [2:0] map_day(input logic [2:0] w);
      map_day = (w == 3'd0 || w == 3'd7) ? 3'd6 : w - 3'd1;
   endfunction

endpackage

@@ rtl/scheduled_thermostat_decider.sv @@
// channel | dir | handshake          | payload
// req     | in  | req_valid/req_stall | req_type: action, sensor sample, slot fields
// rsp     | out | rsp_valid/rsp_stall | rsp_type: averages, setpoint, heat/cool, flags
// csr     | in  | csr_valid/csr_ready | csr_index, csr_data (register write)
//
// a sample goes through accept, ring read, update, slot scan (a start step, then one slot
// compare per cycle from the slot memory) and decide; slot writes, day clears and ignored
// items are handled at accept and leave the block idle
// reset is synchronous, active high; rings start as zeros through per-entry valid bits
// req_stall is high from accept until the result is placed in the output register;
// decide waits while the output register still holds a stalled result, and the output
// register then waits on rsp_stall while the next item may be accepted
module scheduled_thermostat_decider
   import std_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;  // ring memories being read
   localparam logic [2:0] ST_UPD  = 3'd2;  // sums and rings updated
   localparam logic [2:0] ST_SCAN = 3'd3;  // one slot compared per cycle
   localparam logic [2:0] ST_DEC  = 3'd4;  // heat/cool decision, waits for output register

   logic [2:0] state_ff, state_in;

   // configuration
   logic [8:0]         thr_ff;
   logic [6:0]         ofs_ff;
   logic signed [11:0] dflt_ff;

   // captured item
   req_type item_ff;

   // rings: long one is a memory with valid bits
   logic signed [11:0] st_ring_ff [ShortLen];
   logic [9:0]         sh_ring_ff [ShortLen];
   logic signed [11:0] lt_mem [LongLen];
   logic [LongLen-1:0] lt_vld_ff;
   logic signed [11:0] lt_rd_ff;
   logic [ShortLen-1:0] st_vld_ff;

   logic signed [ShortK+12:0] st_sum_ff;
   logic signed [LongK+12:0]  lt_sum_ff;
   logic [ShortK+10:0]        sh_sum_ff;
   logic [ShortK-1:0] st_ptr_ff;
   logic [LongK-1:0]  lt_ptr_ff;
   logic [ShortK:0]   st_fill_ff;
   logic [LongK:0]    lt_fill_ff;

   // schedule
   slot_type slot_mem [NumDays*SlotsPerDay];
   slot_type slot_rd_ff;
   logic [CntW-1:0] cnt_ff [NumDays];
   logic [CntW-1:0] scan_ff;
   logic            rd_pend_ff;
   logic [2:0]      day_ff;

   logic signed [11:0] setp_ff;
   logic signed [3:0]  aday_ff, aslot_ff;
   logic heat_ff, cool_ff, chg_ff;

   logic signed [11:0] ct_ff, s_ff, l_ff;
   logic [9:0]         h_ff;
   logic signed [11:0] p_ct_ff, p_s_ff, p_l_ff;
   logic [9:0]         p_hum_ff, p_h_ff;

   logic    out_vld_ff;
   rsp_type out_ff;

   logic accept;
   logic out_free;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // corrected temperature, saturating at the bottom
   logic signed [12:0] ct_wide;
   logic signed [11:0] ct_val;
   assign ct_wide = 13'(item_ff.temperature) - 13'(signed'({1'b0, ofs_ff}));
   assign ct_val  = (ct_wide < -13'sd2048) ? -12'sd2048 : ct_wide[11:0];

   // slot match for the current scan entry
   logic [SlotAddrW-1:0] slot_addr;
   logic                 hit;
   logic [CntW-1:0]      cnt_lim;
   assign slot_addr = SlotAddrW'(day_ff * SlotsPerDay) + SlotAddrW'(scan_ff);
   assign hit = (item_ff.minute_of_day >= slot_rd_ff.start) &&
                (item_ff.minute_of_day <= slot_rd_ff.stop);
   assign cnt_lim = cnt_ff[day_ff];

   // decision band
   logic signed [13:0] thr_s, on_v, off_v, sp_v;
   always_comb begin
      thr_s = 14'(signed'({1'b0, thr_ff}));
      sp_v  = (aslot_ff < 0) ? 14'(dflt_ff) : 14'(setp_ff);
      on_v  = 14'(l_ff);
      if (on_v < thr_s) on_v = 14'(s_ff);
      if (on_v < thr_s) on_v = 14'(ct_ff);
      off_v = 14'(s_ff);
      if (off_v < thr_s) off_v = 14'(ct_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            priority if (req_data.action == ACT_SAMPLE && req_data.read_ok) state_in = ST_READ;
            else state_in = ST_IDLE;
         end
         ST_READ: state_in = ST_UPD;
         ST_UPD:  state_in = ST_SCAN;
         ST_SCAN: if (rd_pend_ff && hit) state_in = ST_DEC;
                  else if (scan_ff >= cnt_lim || scan_ff >= CntW'(SlotsPerDay))
                     state_in = ST_DEC;
         ST_DEC:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // scan reads one entry per cycle, registered; scan_ff points at next to read
   logic scan_done;
   assign scan_done = (state_ff == ST_SCAN) &&
                      ((rd_pend_ff && hit) || scan_ff >= cnt_lim);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         thr_ff     <= 9'd10;
         ofs_ff     <= 7'd30;
         dflt_ff    <= 12'sd200;
         st_vld_ff  <= '0;
         lt_vld_ff  <= '0;
         st_sum_ff  <= '0;
         lt_sum_ff  <= '0;
         sh_sum_ff  <= '0;
         st_ptr_ff  <= '0;
         lt_ptr_ff  <= '0;
         st_fill_ff <= (ShortK+1)'(ShortLen - 1);
         lt_fill_ff <= (LongK+1)'(LongLen - 1);
         for (int d = 0; d < NumDays; d++) cnt_ff[d] <= '0;
         setp_ff    <= 12'sd200;
         aday_ff    <= -4'sd1;
         aslot_ff   <= -4'sd1;
         heat_ff    <= 1'b0;
         cool_ff    <= 1'b0;
         p_ct_ff    <= '0;
         p_s_ff     <= '0;
         p_l_ff     <= '0;
         p_hum_ff   <= '0;
         p_h_ff     <= '0;
         out_vld_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         scan_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff  <= csr_data[8:0];
               CSR_OFFSET:    ofs_ff  <= csr_data[6:0];
               CSR_DEFAULT:   dflt_ff <= signed'(csr_data);
               default: ;
            endcase
         end

         if (accept) begin
            item_ff <= req_data;
            day_ff  <= map_day(req_data.weekday);
            unique case (req_data.action)
               ACT_WRITE: cnt_ff[map_day(req_data.weekday)] <=
                             CntW'(req_data.slot_index) + CntW'(1);
               ACT_CLEAR: cnt_ff[map_day(req_data.weekday)] <= '0;
               default: ;
            endcase
         end

         if (state_ff == ST_UPD) begin
            // sums add new value, drop the one leaving the window
            logic signed [ShortK+12:0] st_new;
            logic signed [LongK+12:0]  lt_new;
            logic [ShortK+10:0]        sh_new;
            logic [ShortK-1:0]         st_nxt;
            logic [LongK-1:0]          lt_nxt;
            st_new = st_sum_ff + (ShortK+13)'(ct_val);
            lt_new = lt_sum_ff + (LongK+13)'(ct_val);
            sh_new = sh_sum_ff + (ShortK+11)'(item_ff.humidity);
            st_nxt = st_ptr_ff + 1'b1;
            lt_nxt = lt_ptr_ff + 1'b1;
            ct_ff <= ct_val;
            st_ring_ff[st_ptr_ff] <= ct_val;
            sh_ring_ff[st_ptr_ff] <= item_ff.humidity;
            st_vld_ff[st_ptr_ff]  <= 1'b1;
            lt_vld_ff[lt_ptr_ff]  <= 1'b1;
            st_ptr_ff <= st_nxt;
            lt_ptr_ff <= lt_nxt;
            if (st_fill_ff != '0) begin
               st_fill_ff <= st_fill_ff - 1'b1;
               st_sum_ff  <= st_new;
               sh_sum_ff  <= sh_new;
               s_ff <= '0;
               h_ff <= '0;
            end else begin
               s_ff <= 12'(st_new >>> ShortK);
               h_ff <= 10'(sh_new >> ShortK);
               st_sum_ff <= st_new - (ShortK+13)'(st_vld_ff[st_nxt] ?
                            st_ring_ff[st_nxt] : 12'sd0);
               sh_sum_ff <= sh_new - (ShortK+11)'(st_vld_ff[st_nxt] ?
                            sh_ring_ff[st_nxt] : 10'd0);
            end
            if (lt_fill_ff != '0) begin
               lt_fill_ff <= lt_fill_ff - 1'b1;
               lt_sum_ff  <= lt_new;
               l_ff <= '0;
            end else begin
               l_ff <= 12'(lt_new >>> LongK);
               lt_sum_ff <= lt_new - (LongK+13)'(lt_rd_ff);
            end
            scan_ff    <= '0;
            rd_pend_ff <= 1'b0;
         end

         if (state_ff == ST_SCAN) begin
            if (scan_done) begin
               rd_pend_ff <= 1'b0;
               if (rd_pend_ff && hit) begin
                  logic [SlotW-1:0] idx;
                  idx = SlotW'(scan_ff - 1'b1);
                  if (4'(signed'({1'b0, day_ff})) != aday_ff ||
                      4'(signed'({1'b0, idx})) != aslot_ff) begin
                     aday_ff  <= 4'(signed'({1'b0, day_ff}));
                     aslot_ff <= 4'(signed'({1'b0, idx}));
                     setp_ff  <= slot_rd_ff.sp;
                     chg_ff   <= 1'b1;
                  end
               end
            end else begin
               rd_pend_ff <= 1'b1;
               scan_ff    <= scan_ff + 1'b1;
            end
         end
         if (state_ff == ST_UPD) chg_ff <= 1'b0;

         // decide only once the output register can take the result
         if (state_ff == ST_DEC && out_free) begin
            logic hn, cn;
            hn = heat_ff;
            cn = cool_ff;
            if (sp_v > thr_s + on_v) begin
               hn = 1'b1; cn = 1'b0;
            end else if (sp_v < off_v - thr_s) begin
               hn = 1'b0; cn = 1'b1;
            end
            heat_ff <= hn;
            cool_ff <= cn;
            p_ct_ff <= ct_ff; p_s_ff <= s_ff; p_l_ff <= l_ff;
            p_hum_ff <= item_ff.humidity; p_h_ff <= h_ff;
            out_ff.corrected_temp  <= ct_ff;
            out_ff.avg_temp_short  <= s_ff;
            out_ff.avg_temp_long   <= l_ff;
            out_ff.avg_humid_short <= h_ff;
            out_ff.active_setpoint <= sp_v[11:0];
            out_ff.need_heating    <= hn;
            out_ff.need_cooling    <= cn;
            out_ff.program_day     <= aday_ff;
            out_ff.program_slot    <= aslot_ff;
            out_ff.report_changed  <= chg_ff || ct_ff != p_ct_ff ||
                                      item_ff.humidity != p_hum_ff || s_ff != p_s_ff ||
                                      l_ff != p_l_ff || h_ff != p_h_ff;
         end

         if (state_ff == ST_DEC && out_free) out_vld_ff <= 1'b1;
         else if (!rsp_stall) out_vld_ff <= 1'b0;
      end
   end

   // long ring memory: read entry leaving the window, write new sample
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ)
         lt_rd_ff <= lt_vld_ff[LongK'(lt_ptr_ff + 1'b1)] ?
                     lt_mem[LongK'(lt_ptr_ff + 1'b1)] : 12'sd0;
      if (state_ff == ST_UPD) lt_mem[lt_ptr_ff] <= ct_val;
   end

   // schedule slot memory
   always_ff @(posedge clock) begin
      if (accept && req_data.action == ACT_WRITE)
         slot_mem[SlotAddrW'(map_day(req_data.weekday) * SlotsPerDay) +
                  SlotAddrW'(req_data.slot_index)] <=
            '{sp: req_data.slot_setpoint, start: req_data.slot_start,
              stop: req_data.slot_end};
      slot_rd_ff <= slot_mem[slot_addr];
   end

`ifndef SYNTHESIS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> req_stall)
      else $error("input taken during slot scan");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(heat_ff && cool_ff))
      else $error("heating and cooling both requested");
`endif

endmodule

@@ verif/scheduled_thermostat_decider_checker.sv @@
`timescale 1ns / 1ps

module scheduled_thermostat_decider_checker
   import std_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   // thermostat settings as last written
   int threshold;
   int offset;
   int default_sp;

   // three moving-average windows: 0 short temp, 1 long temp, 2 short humidity
   int win_len[3]   = '{ShortLen, LongLen, ShortLen};
   int win_shift[3] = '{ShortK, LongK, ShortK};
   int win_ring[3][LongLen];
   int win_sum[3];
   int win_ptr[3];
   int win_fill[3];

   // schedule
   int slot_sp[NumDays][SlotsPerDay];
   int slot_lo[NumDays][SlotsPerDay];
   int slot_hi[NumDays][SlotsPerDay];
   int day_cnt[NumDays];

   int held_sp, cur_day, cur_slot;
   bit heating, cooling;
   int last_ct, last_hum, last_s, last_l, last_h;

   rsp_type readings_due[$];
   int      errors;

   task automatic reset_model();
      threshold  = 10;
      offset     = 30;
      default_sp = 200;
      for (int w = 0; w < 3; w++) begin
         for (int i = 0; i < LongLen; i++) win_ring[w][i] = 0;
         win_sum[w]  = 0;
         win_ptr[w]  = 0;
         win_fill[w] = win_len[w] - 1;
      end
      for (int d = 0; d < NumDays; d++) day_cnt[d] = 0;
      held_sp  = 200;
      cur_day  = -1;
      cur_slot = -1;
      heating  = 1'b0;
      cooling  = 1'b0;
      last_ct  = 0; last_hum = 0; last_s = 0; last_l = 0; last_h = 0;
   endtask

   // pushes one value into a window, returns the average or 0 while filling
   function automatic int slide_window(int w, int x);
      int r;
      win_sum[w] += x;
      win_ring[w][win_ptr[w]] = x;
      win_ptr[w] = (win_ptr[w] + 1) % win_len[w];
      if (win_fill[w] != 0) begin
         win_fill[w]--;
         return 0;
      end
      r = win_sum[w] >>> win_shift[w];
      win_sum[w] -= win_ring[w][win_ptr[w]];
      return r;
   endfunction

   // applies one request to the model; returns 1 with the reading when one is due
   function automatic bit thermostat_step(input req_type r, output rsp_type p);
      int day, ct, hum, s, l, h, sp, on_lvl, off_lvl, hit, minute;
      bit changed;
      day = (r.weekday == 3'd0 || r.weekday == 3'd7) ? 6 : int'(r.weekday) - 1;
      p = '0;
      if (r.action == ACT_WRITE) begin
         slot_sp[day][r.slot_index] = int'($signed(r.slot_setpoint));
         slot_lo[day][r.slot_index] = int'(r.slot_start);
         slot_hi[day][r.slot_index] = int'(r.slot_end);
         day_cnt[day] = int'(r.slot_index) + 1;
         return 1'b0;
      end
      if (r.action == ACT_CLEAR) begin
         day_cnt[day] = 0;
         return 1'b0;
      end
      if (r.action != ACT_SAMPLE || !r.read_ok) return 1'b0;

      ct = int'($signed(r.temperature));
      ct = ct - offset;
      if (ct < -2048) ct = -2048;
      hum = int'(r.humidity);
      s = slide_window(0, ct);
      l = slide_window(1, ct);
      h = slide_window(2, hum);

      minute = int'(r.minute_of_day);
      hit = -1;
      for (int i = 0; i < day_cnt[day]; i++) begin
         if (hit < 0 && minute >= slot_lo[day][i] && minute <= slot_hi[day][i])
            hit = i;
      end
      changed = 1'b0;
      if (hit >= 0 && (day != cur_day || hit != cur_slot)) begin
         cur_day  = day;
         cur_slot = hit;
         held_sp  = slot_sp[day][hit];
         changed  = 1'b1;
      end
      sp = (cur_slot < 0) ? default_sp : held_sp;

      // heat below the band, cool above it, hold in between
      on_lvl = l;
      if (on_lvl < threshold) on_lvl = s;
      if (on_lvl < threshold) on_lvl = ct;
      off_lvl = s;
      if (off_lvl < threshold) off_lvl = ct;
      if (sp > threshold + on_lvl) begin
         heating = 1'b1; cooling = 1'b0;
      end else if (sp < off_lvl - threshold) begin
         heating = 1'b0; cooling = 1'b1;
      end

      if (ct != last_ct || hum != last_hum || s != last_s || l != last_l || h != last_h)
         changed = 1'b1;
      last_ct = ct; last_hum = hum; last_s = s; last_l = l; last_h = h;

      p.corrected_temp  = ct[11:0];
      p.avg_temp_short  = s[11:0];
      p.avg_temp_long   = l[11:0];
      p.avg_humid_short = h[9:0];
      p.active_setpoint = sp[11:0];
      p.need_heating    = heating;
      p.need_cooling    = cooling;
      p.program_day     = cur_day[3:0];
      p.program_slot    = cur_slot[3:0];
      p.report_changed  = changed;
      return 1'b1;
   endfunction

   task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         reset_model();
         readings_due.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: threshold  = int'(csr_data[8:0]);
               CSR_OFFSET:    offset     = int'(csr_data[6:0]);
               CSR_DEFAULT:   default_sp = int'($signed(csr_data));
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (thermostat_step(req_data, want)) readings_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (readings_due.size() == 0) begin
               $display("%0t unexpected reading transfer: actual %h", $time, got);
               errors++;
            end else begin
               want = readings_due.pop_front();
               check_field("corrected_temp", want.corrected_temp, got.corrected_temp);
               check_field("avg_temp_short", want.avg_temp_short, got.avg_temp_short);
               check_field("avg_temp_long", want.avg_temp_long, got.avg_temp_long);
               check_field("avg_humid_short", 12'(want.avg_humid_short),
                           12'(got.avg_humid_short));
               check_field("active_setpoint", want.active_setpoint, got.active_setpoint);
               check_field("need_heating", 12'(want.need_heating), 12'(got.need_heating));
               check_field("need_cooling", 12'(want.need_cooling), 12'(got.need_cooling));
               check_field("program_day", 12'(want.program_day), 12'(got.program_day));
               check_field("program_slot", 12'(want.program_slot), 12'(got.program_slot));
               check_field("report_changed", 12'(want.report_changed),
                           12'(got.report_changed));
            end
         end
      end
      fail_count    <= errors;
      pending_count <= readings_due.size();
   end

endmodule

@@ verif/scheduled_thermostat_decider_tb.sv @@
`timescale 1ns / 1ps

module scheduled_thermostat_decider_tb;
   import std_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   int fail_count;
   int pending_count;

   // knobs shared between the stimulus and the receiver, then stimulus-only state
   int rsp_hold  = 0;   // long receiver hold-off, in cycles
   bit no_gaps   = 0;   // both sides run back to back
   int written_top[NumDays];  // highest slot index ever written per day
   int drift_temp = 200;

   scheduled_thermostat_decider DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   scheduled_thermostat_decider_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // safety net against a hung handshake
   initial begin
      #20ms;
      $display("[scheduled_thermostat_decider] ERROR");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 2);
      if (pick < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // receiver: random stall stretches, long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else if (no_gaps) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = gap_length();
         end
      end
   end

   // one request transfer; valid stays up between back-to-back items
   task automatic send(input req_type item);
      int gap;
      gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain every pending reading, then give slot writes time to finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (30) @(posedge clock);
   endtask

   function automatic int day_of(input logic [2:0] w);
      return (w == 3'd0 || w == 3'd7) ? 6 : int'(w) - 1;
   endfunction

   function automatic req_type sample(input logic [2:0] w, input logic [10:0] minute,
                                      input logic [11:0] temp, input logic [9:0] hum);
      req_type it;
      it = '0;
      it.action        = ACT_SAMPLE;
      it.read_ok       = 1'b1;
      it.temperature   = temp;
      it.humidity      = hum;
      it.weekday       = w;
      it.minute_of_day = minute;
      // unused fields still toggle
      it.slot_index    = 3'($urandom);
      it.slot_setpoint = 12'($urandom);
      it.slot_start    = 11'($urandom);
      it.slot_end      = 11'($urandom);
      return it;
   endfunction

   // slot write; only indexes whose predecessors were written at some point
   function automatic req_type slot_write(input logic [2:0] w, input logic [2:0] idx,
                                          input logic [11:0] sp, input logic [10:0] lo,
                                          input logic [10:0] hi);
      req_type it;
      it = '0;
      it.action        = ACT_WRITE;
      it.weekday       = w;
      it.slot_index    = idx;
      it.slot_setpoint = sp;
      it.slot_start    = lo;
      it.slot_end      = hi;
      it.read_ok       = 1'($urandom);
      it.temperature   = 12'($urandom);
      it.humidity      = 10'($urandom);
      it.minute_of_day = 11'($urandom);
      if (int'(idx) > written_top[day_of(w)]) written_top[day_of(w)] = int'(idx);
      return it;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int pick, day, top_idx, lo, hi;
      logic [2:0] w;
      logic [11:0] temp;
      logic [9:0] hum;
      logic [10:0] minute;
      pick = $urandom_range(0, 99);
      w = 3'($urandom);
      day = day_of(w);
      if (pick < 80) begin
         // drifting temperature near typical room values, sometimes anything
         drift_temp += int'($urandom_range(0, 60)) - 30;
         if (drift_temp < -400) drift_temp = -400;
         if (drift_temp > 1250) drift_temp = 1250;
         temp   = ($urandom_range(0, 9) == 0) ? 12'($urandom) : drift_temp[11:0];
         hum    = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1000));
         minute = ($urandom_range(0, 19) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1439));
         it = sample(w, minute, temp, hum);
      end else if (pick < 92) begin
         top_idx = written_top[day] + 1;
         if (top_idx > SlotsPerDay - 1) top_idx = SlotsPerDay - 1;
         lo = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1439);
         hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : lo + $urandom_range(0, 400);
         if (hi > 2047) hi = 2047;
         it = slot_write(w, 3'($urandom_range(0, top_idx)),
                         ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                     : 12'($urandom_range(0, 1650) - 400),
                         lo[10:0], hi[10:0]);
      end else if (pick < 95) begin
         it = '0;
         it.action  = ACT_CLEAR;
         it.weekday = w;
      end else begin
         // noise: failed reads and the unused action
         it = sample(w, 11'($urandom), 12'($urandom), 10'($urandom));
         if ($urandom_range(0, 1) == 0) it.read_ok = 1'b0;
         else it.action = 2'd3;
      end
      return it;
   endfunction

   initial begin
      int thr_set[5] = '{10, 0, 500, 511, 37};
      int off_set[5] = '{30, 0, 100, 127, 55};
      int def_set[5] = '{200, -400, 1250, -2048, 2047};
      req_type it;
      for (int d = 0; d < NumDays; d++) written_top[d] = -1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(CSR_THRESHOLD, 12'(thr_set[0]));
      csr_write(CSR_OFFSET, 12'(off_set[0]));
      csr_write(CSR_DEFAULT, 12'(def_set[0]));

      // directed: extremes, default setpoint, slot matching, clearing, ignored items
      send(sample(3'd0, 11'd0, 12'sd2047, 10'd1023));      // no slot yet, default setpoint
      send(sample(3'd7, 11'd1439, -12'sd2048, 10'd0));     // offset saturates low
      it = sample(3'd3, 11'd10, 12'd100, 10'd500);
      it.read_ok = 1'b0;
      send(it);                                            // failed read
      it.read_ok = 1'b1;
      it.action  = 2'd3;
      send(it);                                            // unused action
      send(slot_write(3'd1, 3'd0, -12'sd400, 11'd0, 11'd600));
      send(slot_write(3'd1, 3'd1, 12'sd1250, 11'd500, 11'd1439));
      send(slot_write(3'd0, 3'd0, 12'sd250, 11'd0, 11'd2047));
      send(slot_write(3'd2, 3'd0, 12'sd300, 11'd900, 11'd100));   // empty span
      send(sample(3'd1, 11'd300, 12'd250, 10'd400));       // first slot
      send(sample(3'd1, 11'd550, 12'd250, 10'd400));       // overlap picks first slot
      send(sample(3'd1, 11'd1000, 12'd250, 10'd400));      // second slot
      send(sample(3'd2, 11'd1000, 12'd250, 10'd400));      // no match keeps slot
      send(sample(3'd0, 11'd2047, 12'd1250, 10'd1000));    // sunday slot
      it = '0;
      it.action  = ACT_CLEAR;
      it.weekday = 3'd1;
      send(it);
      send(sample(3'd1, 11'd1000, 12'd250, 10'd400));      // cleared day keeps slot
      send(sample(3'd6, 11'd700, -12'sd400, 10'd999));
      send(sample(3'd4, 11'd720, 12'd1500, 10'd10));
      send(sample(3'd5, 11'd720, 12'd0, 10'd10));

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            wait_idle();
            csr_write(CSR_THRESHOLD, 12'(thr_set[ph]));
            csr_write(CSR_OFFSET, 12'(off_set[ph]));
            csr_write(CSR_DEFAULT, 12'(def_set[ph]));
         end
         no_gaps = (ph == 3);
         for (int n = 0; n < 385; n++) begin
            // receiver holds off while the sender keeps offering samples
            if (ph == 1 && n == 100) rsp_hold = 400;
            // sender pauses until every reading has arrived
            if (ph == 2 && n == 200) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_count != 0);
            end
            send(random_item());
         end
         no_gaps = 0;
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("[scheduled_thermostat_decider] OK");
      end else begin
         $display("[scheduled_thermostat_decider] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/std_pkg.sv
rtl/scheduled_thermostat_decider.sv
verif/scheduled_thermostat_decider_checker.sv
verif/scheduled_thermostat_decider_tb.sv
